@@ src/dqsp_pkg.sv @@
// Shared types and constants of the DNS query stream parser.
package dqsp_pkg;

  // Parser phases.
  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhNameLen = 3'd1;
  localparam logic [2:0] PhLabel   = 3'd2;
  localparam logic [2:0] PhQTail   = 3'd3;
  localparam logic [2:0] PhOptHead = 3'd4;
  localparam logic [2:0] PhOption  = 3'd5;
  localparam logic [2:0] PhAddr    = 3'd6;
  localparam logic [2:0] PhDone    = 3'd7;

  // Result kinds.
  localparam logic [3:0] KindHeader   = 4'd0;
  localparam logic [3:0] KindQdCount  = 4'd1;
  localparam logic [3:0] KindAnCount  = 4'd2;
  localparam logic [3:0] KindNsCount  = 4'd3;
  localparam logic [3:0] KindArCount  = 4'd4;
  localparam logic [3:0] KindNameChar = 4'd5;
  localparam logic [3:0] KindQEnd     = 4'd6;
  localparam logic [3:0] KindSubnet   = 4'd7;
  localparam logic [3:0] KindEnd      = 4'd8;

  // End status codes.
  localparam logic [1:0] StComplete = 2'd0;
  localparam logic [1:0] StTrunc    = 2'd1;
  localparam logic [1:0] StPartial  = 2'd2;

  // Protocol constants.
  localparam logic [23:0] OptType    = 24'd41;
  localparam logic [15:0] MinRdLen   = 16'd12;
  localparam logic [15:0] MinOptLen  = 16'd7;
  localparam logic [15:0] SubnetCode = 16'd8;
  localparam logic [3:0]  HdrLast    = 4'd11;
  localparam logic [7:0]  DotChar    = 8'h2E;

  // Result queue geometry.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic        query_response;
    logic [3:0]  op_code;
    logic        authoritative;
    logic        truncated_bit;
    logic        recursion_desired;
    logic        recursion_available;
    logic [3:0]  response_code;
    logic        last_result;
  } result_t;

  // Up to two results from one byte, packed from slot a.
  typedef struct packed {
    logic [1:0] count;
    result_t    a;
    result_t    b;
  } push_t;

  function automatic result_t mk_result(logic [3:0] kind, logic [31:0] value);
    result_t r;
    r       = '0;
    r.kind  = kind;
    r.value = value;
    return r;
  endfunction

endpackage

@@ src/dqsp_parse.sv @@
// Per-byte parser state and result generation.
module dqsp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_packet_i,
  output dqsp_pkg::push_t     push_o
);
  import dqsp_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] qleft_q, qleft_d;
  logic [7:0]  lbl_q, lbl_d;
  logic        first_q, first_d;
  logic [15:0] optlen_q, optlen_d;
  logic [15:0] optcode_q, optcode_d;

  logic [31:0] sh_new;
  logic [7:0]  lbl_dec;
  logic [15:0] qleft_dec;
  logic        proc_v;
  result_t     proc_r;
  result_t     end_r;
  logic [1:0]  status;

  assign sh_new    = {shift_q[23:0], data_byte_i};
  assign lbl_dec   = lbl_q - 8'd1;
  assign qleft_dec = qleft_q - 16'd1;

  // Next state and the result of the byte itself.
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    qleft_d   = qleft_q;
    lbl_d     = lbl_q;
    first_d   = first_q;
    optlen_d  = optlen_q;
    optcode_d = optcode_q;
    proc_v    = 1'b0;
    proc_r    = '0;
    unique case (phase_q)
      PhHeader: begin
        shift_d = sh_new;
        case (cnt_q)
          4'd3: begin
            proc_v                     = 1'b1;
            proc_r                     = mk_result(KindHeader, {16'd0, sh_new[31:16]});
            proc_r.query_response      = sh_new[15];
            proc_r.op_code             = sh_new[14:11];
            proc_r.authoritative       = sh_new[10];
            proc_r.truncated_bit       = sh_new[9];
            proc_r.recursion_desired   = sh_new[8];
            proc_r.recursion_available = sh_new[7];
            proc_r.response_code       = sh_new[3:0];
          end
          4'd5: begin
            qleft_d = sh_new[15:0];
            proc_v  = 1'b1;
            proc_r  = mk_result(KindQdCount, {16'd0, sh_new[15:0]});
          end
          4'd7: begin
            proc_v = 1'b1;
            proc_r = mk_result(KindAnCount, {16'd0, sh_new[15:0]});
          end
          4'd9: begin
            proc_v = 1'b1;
            proc_r = mk_result(KindNsCount, {16'd0, sh_new[15:0]});
          end
          4'd11: begin
            proc_v = 1'b1;
            proc_r = mk_result(KindArCount, {16'd0, sh_new[15:0]});
          end
          default: ;
        endcase
        if (cnt_q >= HdrLast) begin
          if (qleft_q != 16'd0) begin
            phase_d = PhNameLen;
            first_d = 1'b1;
            cnt_d   = 4'd0;
          end else begin
            phase_d = PhOptHead;
            cnt_d   = 4'd0;
            shift_d = '0;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PhNameLen: begin
        if (data_byte_i == 8'd0) begin
          phase_d = PhQTail;
          cnt_d   = 4'd0;
          shift_d = '0;
        end else begin
          if (!first_q) begin
            proc_v = 1'b1;
            proc_r = mk_result(KindNameChar, {24'd0, DotChar});
          end
          first_d = 1'b0;
          lbl_d   = data_byte_i;
          phase_d = PhLabel;
        end
      end
      PhLabel: begin
        proc_v = 1'b1;
        proc_r = mk_result(KindNameChar, {24'd0, data_byte_i});
        lbl_d  = lbl_dec;
        if (lbl_dec == 8'd0) begin
          phase_d = PhNameLen;
        end
      end
      PhQTail: begin
        shift_d = sh_new;
        if (cnt_q >= 4'd3) begin
          proc_v  = 1'b1;
          proc_r  = mk_result(KindQEnd, sh_new);
          qleft_d = qleft_dec;
          if (qleft_dec != 16'd0) begin
            phase_d = PhNameLen;
            first_d = 1'b1;
            cnt_d   = 4'd0;
          end else begin
            phase_d = PhOptHead;
            cnt_d   = 4'd0;
            shift_d = '0;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PhOptHead: begin
        shift_d = sh_new;
        if (cnt_q == 4'd2 && sh_new[23:0] != OptType) begin
          phase_d = PhDone;
        end else if (cnt_q >= 4'd10) begin
          optlen_d = sh_new[15:0];
          if (sh_new[15:0] < MinRdLen) begin
            phase_d = PhDone;
          end else begin
            phase_d = PhOption;
            cnt_d   = 4'd0;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PhOption: begin
        shift_d = sh_new;
        if (cnt_q == 4'd1) begin
          optcode_d = sh_new[15:0];
        end else if (cnt_q == 4'd3) begin
          optlen_d = sh_new[15:0];
        end
        if (cnt_q >= 4'd7) begin
          if (optlen_q >= MinOptLen && optcode_q == SubnetCode) begin
            phase_d = PhAddr;
            cnt_d   = 4'd0;
          end else begin
            phase_d = PhDone;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PhAddr: begin
        shift_d = sh_new;
        if (cnt_q >= 4'd3) begin
          proc_v  = 1'b1;
          proc_r  = mk_result(KindSubnet, sh_new);
          phase_d = PhDone;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      default: begin
        phase_d = PhDone;
      end
    endcase
  end

  // Completion status as seen after this byte.
  always_comb begin
    if (phase_d == PhHeader || phase_d == PhNameLen ||
        phase_d == PhLabel || phase_d == PhQTail) begin
      status = StTrunc;
    end else if (phase_d == PhDone || (phase_d == PhOptHead && cnt_d == 4'd0)) begin
      status = StComplete;
    end else begin
      status = StPartial;
    end
    end_r             = mk_result(KindEnd, {30'd0, status});
    end_r.last_result = 1'b1;
  end

  // Pack the results of this byte, the byte's own result first.
  always_comb begin
    push_o = '0;
    if (accept_i) begin
      if (proc_v) begin
        push_o.a = proc_r;
        push_o.b = end_r;
        push_o.count = end_of_packet_i ? 2'd2 : 2'd1;
      end else begin
        push_o.a = end_r;
        push_o.count = end_of_packet_i ? 2'd1 : 2'd0;
      end
    end
  end

  // State registers; the final byte of a packet returns to reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      cnt_q     <= '0;
      shift_q   <= '0;
      qleft_q   <= '0;
      lbl_q     <= '0;
      first_q   <= 1'b1;
      optlen_q  <= '0;
      optcode_q <= '0;
    end else if (accept_i) begin
      if (end_of_packet_i) begin
        phase_q   <= PhHeader;
        cnt_q     <= '0;
        shift_q   <= '0;
        qleft_q   <= '0;
        lbl_q     <= '0;
        first_q   <= 1'b1;
        optlen_q  <= '0;
        optcode_q <= '0;
      end else begin
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        shift_q   <= shift_d;
        qleft_q   <= qleft_d;
        lbl_q     <= lbl_d;
        first_q   <= first_d;
        optlen_q  <= optlen_d;
        optcode_q <= optcode_d;
      end
    end
  end

endmodule

@@ src/dqsp_outq.sv @@
// Small result queue: takes up to two results a cycle, gives one while stall_i is low.
module dqsp_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqsp_pkg::push_t     push_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                stall_i,
  output dqsp_pkg::result_t   data_o
);
  import dqsp_pkg::*;

  result_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d;
  logic [QPtrW-1:0]  rd_q, rd_d;
  logic [QPtrW:0]    cnt_q, cnt_d;
  logic [QPtrW-1:0]  wr_next;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && !stall_i;
  // Room for two results must be left for the next request.
  assign full_o  = (cnt_q > (QPtrW+1)'(QDepth - 2));
  assign wr_next = wr_q + QPtrW'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q + QPtrW'(push_i.count);
    rd_d  = pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(push_i.count) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.a;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.b;
    end
  end

endmodule

@@ src/dqsp_core_top.sv @@
// Parser and result queue wired together below the top level.
module dqsp_core_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_packet_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                stall_i,
  output dqsp_pkg::result_t   data_o
);
  import dqsp_pkg::*;

  push_t push;

  // Parser feeding the result queue.
  dqsp_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept_i),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .push_o          (push)
  );

  dqsp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full_o),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .data_o  (data_o)
  );

endmodule

@@ src/dns_query_stream_parser_core.sv @@
// Top level of the DNS query stream parser.
//
// Input channel: one message byte per request (data_byte_i, end_of_packet_i)
// under in_valid_i / in_stall_o. A byte is taken at a rising edge with
// in_valid_i high and in_stall_o low. The final byte of a message is
// flagged by end_of_packet_i.
// Output channel: one result per request (kind_o, value_o, header flags,
// last_result_o) under out_valid_o / out_stall_i.
// Results are registered in the result queue and reach the output in
// order, behind any results already queued. Throughput: one byte per
// cycle while in_stall_o is low. The parser updates its state in the
// cycle a byte is taken and writes its results into a four-entry result
// queue. A final byte with its own result gives two, which drain in turn.
// in_stall_o rises while the queue holds more than two results, so a held
// out_stall_i backs up into the input channel; no result is lost.
// Reset clears the parser to the start of a message and empties the queue.
module dns_query_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [31:0] value_o,
  output logic        query_response_o,
  output logic [3:0]  op_code_o,
  output logic        authoritative_o,
  output logic        truncated_bit_o,
  output logic        recursion_desired_o,
  output logic        recursion_available_o,
  output logic [3:0]  response_code_o,
  output logic        last_result_o
);
  import dqsp_pkg::*;

  logic    accept;
  logic    full;
  result_t res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  dqsp_core_top u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .full_o          (full),
    .valid_o         (out_valid_o),
    .stall_i         (out_stall_i),
    .data_o          (res)
  );

  // Unpack the head result onto the ports.
  assign kind_o                = res.kind;
  assign value_o               = res.value;
  assign query_response_o      = res.query_response;
  assign op_code_o             = res.op_code;
  assign authoritative_o       = res.authoritative;
  assign truncated_bit_o       = res.truncated_bit;
  assign recursion_desired_o   = res.recursion_desired;
  assign recursion_available_o = res.recursion_available;
  assign response_code_o       = res.response_code;
  assign last_result_o         = res.last_result;

endmodule

@@ test/tb_dns_query_stream_parser_core.sv @@
// Self-checking testbench for the DNS query stream parser core.
module tb_dns_query_stream_parser_core;
  import dqsp_pkg::*;

  localparam int unsigned RunLimit  = 200000;
  localparam int unsigned ByteGoal  = 1200;
  localparam int unsigned HoldStart = 150;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned DrainWait = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } wire_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_packet_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  kind_o;
  logic [31:0] value_o;
  logic        query_response_o;
  logic [3:0]  op_code_o;
  logic        authoritative_o;
  logic        truncated_bit_o;
  logic        recursion_desired_o;
  logic        recursion_available_o;
  logic [3:0]  response_code_o;
  logic        last_result_o;

  dns_query_stream_parser_core uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .data_byte_i           (data_byte_i),
    .end_of_packet_i       (end_of_packet_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .kind_o                (kind_o),
    .value_o               (value_o),
    .query_response_o      (query_response_o),
    .op_code_o             (op_code_o),
    .authoritative_o       (authoritative_o),
    .truncated_bit_o       (truncated_bit_o),
    .recursion_desired_o   (recursion_desired_o),
    .recursion_available_o (recursion_available_o),
    .response_code_o       (response_code_o),
    .last_result_o         (last_result_o)
  );

  // Bytes waiting to be sent and results waiting to be seen.
  wire_item_t  wire_bytes[$];
  result_t     pending_results[$];
  logic [7:0]  pkt[$];

  int unsigned err_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // Parser state as the block should hold it.
  logic [2:0]  pr_phase;
  logic [3:0]  pr_count;
  logic [31:0] pr_shift;
  logic [15:0] pr_qleft;
  logic [7:0]  pr_label_left;
  logic        pr_first;
  logic [15:0] pr_opt_len;
  logic [15:0] pr_opt_code;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic parser_clear();
    pr_phase      = PhHeader;
    pr_count      = 4'd0;
    pr_shift      = 32'h0;
    pr_qleft      = 16'h0;
    pr_label_left = 8'h0;
    pr_first      = 1'b1;
    pr_opt_len    = 16'h0;
    pr_opt_code   = 16'h0;
  endtask

  task automatic expect_result(input logic [3:0] kind, input logic [31:0] value);
    result_t r;
    r       = '0;
    r.kind  = kind;
    r.value = value;
    pending_results.push_back(r);
  endtask

  task automatic start_question();
    pr_phase = PhNameLen;
    pr_first = 1'b1;
    pr_count = 4'd0;
  endtask

  task automatic enter_opt_check();
    pr_phase = PhOptHead;
    pr_count = 4'd0;
    pr_shift = 32'h0;
  endtask

  // Advance the expected parser state by one byte and queue its results.
  task automatic parse_byte(input logic [7:0] b, input logic eop);
    logic [3:0] cnt;
    logic [1:0] status;
    result_t    r;
    cnt = pr_count;
    case (pr_phase)
      PhHeader: begin
        pr_shift = {pr_shift[23:0], b};
        if (cnt == 4'd3) begin
          r                     = '0;
          r.kind                = KindHeader;
          r.value               = {16'h0, pr_shift[31:16]};
          r.query_response      = pr_shift[15];
          r.op_code             = pr_shift[14:11];
          r.authoritative       = pr_shift[10];
          r.truncated_bit       = pr_shift[9];
          r.recursion_desired   = pr_shift[8];
          r.recursion_available = pr_shift[7];
          r.response_code       = pr_shift[3:0];
          pending_results.push_back(r);
        end else if (cnt == 4'd5) begin
          pr_qleft = pr_shift[15:0];
          expect_result(KindQdCount, {16'h0, pr_shift[15:0]});
        end else if (cnt == 4'd7) begin
          expect_result(KindAnCount, {16'h0, pr_shift[15:0]});
        end else if (cnt == 4'd9) begin
          expect_result(KindNsCount, {16'h0, pr_shift[15:0]});
        end else if (cnt == HdrLast) begin
          expect_result(KindArCount, {16'h0, pr_shift[15:0]});
        end
        if (cnt >= HdrLast) begin
          if (pr_qleft != 16'h0) start_question();
          else enter_opt_check();
        end else begin
          pr_count = cnt + 4'd1;
        end
      end
      PhNameLen: begin
        if (b == 8'h00) begin
          pr_phase = PhQTail;
          pr_count = 4'd0;
          pr_shift = 32'h0;
        end else begin
          // Labels after the first are separated by a dot.
          if (!pr_first) expect_result(KindNameChar, {24'h0, DotChar});
          pr_first      = 1'b0;
          pr_label_left = b;
          pr_phase      = PhLabel;
        end
      end
      PhLabel: begin
        expect_result(KindNameChar, {24'h0, b});
        pr_label_left = pr_label_left - 8'd1;
        if (pr_label_left == 8'h00) pr_phase = PhNameLen;
      end
      PhQTail: begin
        pr_shift = {pr_shift[23:0], b};
        if (cnt >= 4'd3) begin
          expect_result(KindQEnd, pr_shift);
          pr_qleft = pr_qleft - 16'd1;
          if (pr_qleft != 16'h0) start_question();
          else enter_opt_check();
        end else begin
          pr_count = cnt + 4'd1;
        end
      end
      PhOptHead: begin
        pr_shift = {pr_shift[23:0], b};
        if (cnt == 4'd2 && pr_shift[23:0] != OptType) begin
          pr_phase = PhDone;
        end else if (cnt >= 4'd10) begin
          pr_opt_len = pr_shift[15:0];
          if (pr_opt_len < MinRdLen) begin
            pr_phase = PhDone;
          end else begin
            pr_phase = PhOption;
            pr_count = 4'd0;
          end
        end else begin
          pr_count = cnt + 4'd1;
        end
      end
      PhOption: begin
        pr_shift = {pr_shift[23:0], b};
        if (cnt == 4'd1) pr_opt_code = pr_shift[15:0];
        else if (cnt == 4'd3) pr_opt_len = pr_shift[15:0];
        if (cnt >= 4'd7) begin
          if (pr_opt_len >= MinOptLen && pr_opt_code == SubnetCode) begin
            pr_phase = PhAddr;
            pr_count = 4'd0;
          end else begin
            pr_phase = PhDone;
          end
        end else begin
          pr_count = cnt + 4'd1;
        end
      end
      PhAddr: begin
        pr_shift = {pr_shift[23:0], b};
        if (cnt >= 4'd3) begin
          expect_result(KindSubnet, pr_shift);
          pr_phase = PhDone;
        end else begin
          pr_count = cnt + 4'd1;
        end
      end
      default: begin
        pr_phase = PhDone;
      end
    endcase

    if (pr_phase == PhHeader || pr_phase == PhNameLen ||
        pr_phase == PhLabel || pr_phase == PhQTail) begin
      status = StTrunc;
    end else if (pr_phase == PhDone ||
                 (pr_phase == PhOptHead && pr_count == 4'd0)) begin
      status = StComplete;
    end else begin
      status = StPartial;
    end

    // The final byte closes the packet with its status.
    if (eop) begin
      r             = '0;
      r.kind        = KindEnd;
      r.value       = {30'h0, status};
      r.last_result = 1'b1;
      pending_results.push_back(r);
      parser_clear();
    end
  endtask

  task automatic log_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  task automatic put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  // Move the first len bytes of the packet buffer to the send queue.
  task automatic queue_packet(input int unsigned len);
    wire_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.data = pkt[i];
      it.eop  = (i == len - 1);
      wire_bytes.push_back(it);
    end
  endtask

  // Build one query: header, questions, then an optional OPT record.
  task automatic build_query();
    int unsigned qd;
    int unsigned nlabels;
    int unsigned llen;
    int unsigned opt_mode;
    int unsigned pick;
    logic [15:0] rdlen;
    logic [15:0] olen;
    pkt.delete();
    pick = $urandom_range(0, 9);
    qd = (pick == 0) ? 0 : (pick <= 6) ? 1 : (pick <= 8) ? 2 : 3;
    opt_mode = $urandom_range(0, 9);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'(qd));
    put16(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0);
    put16(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0);
    put16((opt_mode >= 2) ? 16'd1 : 16'($urandom));
    for (int unsigned q = 0; q < qd; q++) begin
      nlabels = $urandom_range(0, 3);
      for (int unsigned l = 0; l < nlabels; l++) begin
        llen = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 255)
                                             : $urandom_range(1, 8);
        pkt.push_back(llen[7:0]);
        for (int unsigned c = 0; c < llen; c++) begin
          pkt.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'(8'h61 + $urandom_range(0, 25)));
        end
      end
      pkt.push_back(8'h00);
      put16(($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom));
      put16(($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom));
    end
    // Modes: 0-1 none, 2 not EDNS, 3 short RDLEN, 4 other option,
    // 5 short option length, 6-9 proper client subnet.
    if (opt_mode >= 2) begin
      if (opt_mode == 2 && $urandom_range(0, 1) == 0) begin
        pkt.push_back(8'($urandom_range(1, 255)));
        put16(16'd41);
      end else begin
        pkt.push_back(8'h00);
        put16((opt_mode == 2) ? 16'($urandom) : 16'd41);
      end
      put16(16'($urandom));
      put16(16'($urandom));
      put16(16'($urandom));
      rdlen = (opt_mode == 3) ? 16'($urandom_range(0, 11))
                              : 16'(16'd12 + $urandom_range(0, 8));
      put16(rdlen);
      put16((opt_mode == 4) ? 16'($urandom) : 16'd8);
      olen = (opt_mode == 5) ? 16'($urandom_range(0, 6))
                             : 16'(16'd7 + $urandom_range(0, 5));
      put16(olen);
      put16(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1);
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 255)));
      for (int unsigned i = 0; i < 4; i++) pkt.push_back(8'($urandom_range(0, 255)));
    end
    // Occasional bytes past the end of the parsed part.
    if ($urandom_range(0, 3) == 0) begin
      llen = $urandom_range(1, 4);
      for (int unsigned i = 0; i < llen; i++) pkt.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Request sender: presents bytes at the falling edge, with random gaps.
  always @(negedge clk_i) begin : drive_proc
    logic       next_valid;
    wire_item_t cur;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      next_valid = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
      end else if (wire_bytes.size() != 0) begin
        cur = wire_bytes.pop_front();
        data_byte_i     <= cur.data;
        end_of_packet_i <= cur.eop;
        next_valid = 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 9);
      end
      in_valid_i <= next_valid;
    end
  end

  // One long hold-off on the result side so the block backs up its input.
  always @(negedge clk_i) begin : hold_proc
    if (rst_ni) begin
      if (!hold_done && results_seen >= HoldStart) begin
        hold_done <= 1'b1;
        hold_left <= HoldLen;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Result receiver: stalls at random after each result and during the hold-off.
  always @(negedge clk_i) begin : recv_proc
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (hold_left != 0);
      end
    end
  end

  // Watch both channels: check each result, then predict from each byte taken.
  always @(posedge clk_i) begin : monitor_proc
    result_t got;
    result_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        out_taken = 1'b1;
        results_seen++;
        got.kind                = kind_o;
        got.value               = value_o;
        got.query_response      = query_response_o;
        got.op_code             = op_code_o;
        got.authoritative       = authoritative_o;
        got.truncated_bit       = truncated_bit_o;
        got.recursion_desired   = recursion_desired_o;
        got.recursion_available = recursion_available_o;
        got.response_code       = response_code_o;
        got.last_result         = last_result_o;
        if (pending_results.size() == 0) begin
          log_error($sformatf("unexpected result: kind %0d value %h", got.kind, got.value));
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.query_response !== want.query_response ||
              got.op_code !== want.op_code ||
              got.authoritative !== want.authoritative ||
              got.truncated_bit !== want.truncated_bit ||
              got.recursion_desired !== want.recursion_desired ||
              got.recursion_available !== want.recursion_available ||
              got.response_code !== want.response_code ||
              got.last_result !== want.last_result) begin
            log_error($sformatf(
              "mismatch: expected %0d/%h/%b%h%b%b%b%b%h/%b got %0d/%h/%b%h%b%b%b%b%h/%b",
              want.kind, want.value, want.query_response, want.op_code,
              want.authoritative, want.truncated_bit, want.recursion_desired,
              want.recursion_available, want.response_code, want.last_result,
              got.kind, got.value, got.query_response, got.op_code,
              got.authoritative, got.truncated_bit, got.recursion_desired,
              got.recursion_available, got.response_code, got.last_result));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        parse_byte(data_byte_i, end_of_packet_i);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin : watchdog_proc
    cycles++;
    if (cycles >= RunLimit) begin
      $display("tb_dns_query_stream_parser_core: FAIL");
      $finish;
    end
  end

  initial begin : stim_proc
    int unsigned pick;
    parser_clear();

    // Directed: a one-byte packet that ends inside the header.
    pkt.delete();
    pkt.push_back(8'h00);
    queue_packet(pkt.size());
    // Header with every flag set, no questions, extreme counts.
    pkt.delete();
    put16(16'hFFFF);
    put16(16'hFFFF);
    put16(16'h0000);
    put16(16'hFFFF);
    put16(16'h0000);
    put16(16'hFFFF);
    queue_packet(pkt.size());
    // Header with no questions and one additional record, ending inside the OPT header.
    pkt.delete();
    for (int unsigned i = 0; i < 5; i++) put16(16'h0000);
    put16(16'h0001);
    pkt.push_back(8'h00);
    put16(16'd41);
    queue_packet(pkt.size());

    // Random packets: mostly well-formed, some cut short, some noise.
    while (wire_bytes.size() < ByteGoal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_query();
        queue_packet(pkt.size());
      end else if (pick < 88) begin
        build_query();
        queue_packet($urandom_range(1, pkt.size()));
      end else begin
        pkt.delete();
        repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom_range(0, 255)));
        queue_packet(pkt.size());
      end
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all bytes sent, all results seen, then a short settle.
    while (wire_bytes.size() != 0 || in_valid_i) @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_dns_query_stream_parser_core: PASS");
    end else begin
      $display("tb_dns_query_stream_parser_core: FAIL");
    end
    $finish;
  end

endmodule
